### rtl/assert_macros.svh
// Assertion macros for the calibration sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define VHCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define VHCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/vhcs_pkg.sv
// Shared types and constants of the valve hard-stop calibration sequencer.
package vhcs_pkg;

    localparam int ANG_W      = 32;
    localparam int TIME_W     = 32;
    localparam int SEEK_W     = 21;
    localparam int LIMIT_W    = 24;
    localparam int MS_W       = 16;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEEK_STEP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACKING_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_MS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_OFF_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPOWER_MS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_MS        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_POSITION  = 3'd6;

    // calibration phases
    localparam logic [PHASE_W-1:0] PH_SEEK    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SETTLE  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_OFF     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_REPOWER = 3'd3;
    localparam logic [PHASE_W-1:0] PH_HOME    = 3'd4;

    // item operations
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_RESET = 1'b1;

    localparam logic [MS_W-1:0] SETTLE_MS_RST    = 16'd1000;
    localparam logic [MS_W-1:0] POWER_OFF_MS_RST = 16'd4000;
    localparam logic [MS_W-1:0] REPOWER_MS_RST   = 16'd5000;
    localparam logic [MS_W-1:0] HOME_MS_RST      = 16'd6500;

    localparam logic signed [ANG_W-1:0] ANG_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ANG_W-1:0] ANG_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                    op;
        logic [1:0]              valve_sel;
        logic [TIME_W-1:0]       time_ms;
        logic signed [ANG_W-1:0] measured_pos;
        logic signed [ANG_W-1:0] encoder_pos;
    } t_vhcs_in;

    typedef struct packed {
        logic                    drive_enable;
        logic signed [ANG_W-1:0] target_angle;
        logic                    stop_found;
        logic [PHASE_W-1:0]      phase_now;
        logic                    bad_valve;
    } t_vhcs_out;

endpackage

### rtl/vhcs_chan_if.sv
// Valid/ready channel carrying one item of type T.
interface vhcs_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/vhcs_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module vhcs_div
    import vhcs_pkg::*;
#(
    parameter int DV_W = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [SEEK_W-1:0]     i_dividend,
    input  logic [DV_W-1:0]       i_divisor,
    output logic                  o_done,
    output logic [SEEK_W-1:0]     o_quot
);

    localparam int CNT_W = $clog2(SEEK_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DV_W-1:0]   r_rem;
    logic [DV_W-1:0]   r_dvs;
    logic [SEEK_W-1:0] r_dvd;
    logic [DV_W:0]     w_trial;

    // shift the next dividend bit into the remainder and try the subtraction
    assign w_trial = {r_rem, r_dvd[SEEK_W-1]} - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SEEK_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            if (!w_trial[DV_W]) begin
                r_rem <= w_trial[DV_W-1:0];
                r_dvd <= {r_dvd[SEEK_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[DV_W-2:0], r_dvd[SEEK_W-1]};
                r_dvd <= {r_dvd[SEEK_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule

### rtl/valve_hardstop_calibration_sequencer_unit.sv
// Top level of the two-valve hard-stop calibration sequencer.
//
//  channel   | dir | type        | carries
//  ----------+-----+-------------+-----------------------------------------------
//  i_in      | in  | t_vhcs_in   | tick or reset item: op, valve, time, pos, enc
//  o_out     | out | t_vhcs_out  | one result per tick item, none per reset item
//  i_cfg_*   | in  | write port  | seven calibration registers, index 0 to 6
//
// A tracking seek tick steps through exec, mismatch, compare, a wait on the
// bit-serial divider (one quotient bit per cycle over the 21-bit seek step) and
// emit; stop ticks skip the divider, others go exec to emit, resets end at exec.
// Reset is synchronous and active low; it loads the register defaults and
// returns every valve to seek with zero target, offset, pass count and stamp.
// A waiting result sits in the output register while the next item is taken;
// a new result stalls only if the previous one has still not been taken.
`include "assert_macros.svh"

module valve_hardstop_calibration_sequencer_unit
    import vhcs_pkg::*;
#(
    parameter int PASS_MAX      = 255,
    parameter int POS_FRAC_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    vhcs_chan_if.sink             i_in,
    vhcs_chan_if.source           o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // pass counter and divisor widths follow the saturation limit
    localparam int PC_W = $clog2(PASS_MAX + 1);
    localparam int DV_W = PC_W + 1;
    localparam logic [PC_W-1:0] PASS_LIM = PC_W'(PASS_MAX);

    // register defaults in the chosen fixed-point format
    localparam longint unsigned TWO_DEG  = 64'd2 << POS_FRAC_BITS;
    localparam longint unsigned HOME_RAW = 64'd95 << POS_FRAC_BITS;
    localparam logic [SEEK_W-1:0]  SEEK_RST  = SEEK_W'(TWO_DEG / 1000);
    localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(TWO_DEG / 10);
    localparam logic signed [ANG_W-1:0] HOME_RST =
        (HOME_RAW > 64'h7FFF_FFFF) ? ANG_MAX : ANG_W'(HOME_RAW);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MIS  = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    // configuration
    logic [SEEK_W-1:0]       r_seek_step;
    logic [LIMIT_W-1:0]      r_limit;
    logic [MS_W-1:0]         r_settle_ms;
    logic [MS_W-1:0]         r_power_off_ms;
    logic [MS_W-1:0]         r_repower_ms;
    logic [MS_W-1:0]         r_home_ms;
    logic signed [ANG_W-1:0] r_home_pos;

    // calibration state
    logic [PHASE_W-1:0]      r_phase;
    logic [PC_W-1:0]         r_pass;
    logic [TIME_W-1:0]       r_stamp;
    logic                    r_stamp_vld;
    logic signed [ANG_W-1:0] r_target [2];
    logic signed [ANG_W-1:0] r_offset [2];

    // item under work
    logic                    r_op;
    logic                    r_v;
    logic                    r_bad;
    logic [TIME_W-1:0]       r_now;
    logic signed [ANG_W-1:0] r_pos;
    logic signed [ANG_W-1:0] r_enc;

    // working registers
    logic [2:0]              r_state;
    logic signed [ANG_W:0]   r_sum;
    logic signed [ANG_W+1:0] r_mis;
    t_vhcs_out               r_res;
    t_vhcs_out               r_out;
    logic                    r_ov;

    logic                    w_accept;
    logic [TIME_W-1:0]       w_elapsed;
    logic [MS_W-1:0]         w_thr;
    logic [PHASE_W-1:0]      w_next_ph;
    logic                    w_timed;
    logic                    w_adv;
    logic signed [ANG_W+1:0] w_lim_p;
    logic signed [ANG_W+1:0] w_lim_n;
    logic                    w_in_range;
    logic signed [ANG_W:0]   w_rst_diff;
    logic signed [ANG_W:0]   w_tadd;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [SEEK_W-1:0]       w_quot;
    logic [DV_W-1:0]         w_divisor;

    function automatic logic signed [ANG_W-1:0] f_sat(input logic signed [ANG_W:0] v);
        if (v[ANG_W] != v[ANG_W-1]) begin
            f_sat = v[ANG_W] ? ANG_MIN : ANG_MAX;
        end else begin
            f_sat = v[ANG_W-1:0];
        end
    endfunction

    assign w_accept     = i_in.valid && i_in.ready;
    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_ov;
    assign o_out.data   = r_out;

    // time since the captured stamp, modulo 2^32
    assign w_elapsed = r_now - r_stamp;

    // pick the delay of the current timed phase and its successor
    always_comb begin
        w_thr     = r_home_ms;
        w_next_ph = r_phase;
        w_timed   = 1'b0;
        case (r_phase)
            PH_SETTLE: begin
                w_thr     = r_settle_ms;
                w_next_ph = PH_OFF;
                w_timed   = r_stamp_vld;
            end
            PH_OFF: begin
                w_thr     = r_power_off_ms;
                w_next_ph = PH_REPOWER;
                w_timed   = 1'b1;
            end
            PH_REPOWER: begin
                w_thr     = r_repower_ms;
                w_next_ph = PH_HOME;
                w_timed   = 1'b1;
            end
            PH_HOME: begin
                w_thr     = r_home_ms;
                w_next_ph = PH_SEEK;
                w_timed   = 1'b1;
            end
            default: begin
                w_timed = 1'b0;
            end
        endcase
    end

    assign w_adv = w_timed && (w_elapsed >= {{(TIME_W-MS_W){1'b0}}, w_thr});

    // tracking window: |mis| <= limit without negating the mismatch
    assign w_lim_p    = {{(ANG_W+2-LIMIT_W){1'b0}}, r_limit};
    assign w_lim_n    = -w_lim_p;
    assign w_in_range = r_mis[ANG_W+1] ? (r_mis >= w_lim_n) : (r_mis <= w_lim_p);

    assign w_rst_diff = {r_pos[ANG_W-1], r_pos} - {r_enc[ANG_W-1], r_enc};
    assign w_tadd     = {r_target[r_v][ANG_W-1], r_target[r_v]}
                      + {{(ANG_W+1-SEEK_W){1'b0}}, w_quot};

    assign w_div_start = (r_state == S_CMP) && w_in_range;
    assign w_divisor   = {1'b0, r_pass} + DV_W'(1);

    vhcs_div #(
        .DV_W (DV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_seek_step),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seek_step    <= SEEK_RST;
            r_limit        <= LIMIT_RST;
            r_settle_ms    <= SETTLE_MS_RST;
            r_power_off_ms <= POWER_OFF_MS_RST;
            r_repower_ms   <= REPOWER_MS_RST;
            r_home_ms      <= HOME_MS_RST;
            r_home_pos     <= HOME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SEEK_STEP:      r_seek_step    <= i_cfg_data[SEEK_W-1:0];
                CFG_TRACKING_LIMIT: r_limit        <= i_cfg_data[LIMIT_W-1:0];
                CFG_SETTLE_MS:      r_settle_ms    <= i_cfg_data[MS_W-1:0];
                CFG_POWER_OFF_MS:   r_power_off_ms <= i_cfg_data[MS_W-1:0];
                CFG_REPOWER_MS:     r_repower_ms   <= i_cfg_data[MS_W-1:0];
                CFG_HOME_MS:        r_home_ms      <= i_cfg_data[MS_W-1:0];
                CFG_HOME_POSITION:  r_home_pos     <= signed'(i_cfg_data[ANG_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    // capture the item on acceptance
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_in.data.op;
            r_v   <= i_in.data.valve_sel[0];
            r_bad <= i_in.data.valve_sel[1];
            r_now <= i_in.data.time_ms;
            r_pos <= i_in.data.measured_pos;
            r_enc <= i_in.data.encoder_pos;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_SEEK;
            r_pass      <= '0;
            r_stamp     <= '0;
            r_stamp_vld <= 1'b0;
            r_target[0] <= '0;
            r_target[1] <= '0;
            r_offset[0] <= '0;
            r_offset[1] <= '0;
            r_ov        <= 1'b0;
        end else begin
            // load a finished result into a free output register, drop it once taken
            if ((r_state == S_EMIT) && (!r_ov || o_out.ready)) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_op == OP_RESET) begin
                        // restart the sequence on a supported valve, no result
                        if (!r_bad) begin
                            r_phase       <= PH_SEEK;
                            r_pass        <= '0;
                            r_stamp       <= '0;
                            r_stamp_vld   <= 1'b0;
                            r_target[r_v] <= r_enc;
                            r_offset[r_v] <= f_sat(w_rst_diff);
                        end
                        r_state <= S_IDLE;
                    end else if (r_bad) begin
                        r_res   <= '{drive_enable: 1'b0, target_angle: '0, stop_found: 1'b0,
                                     phase_now: '0, bad_valve: 1'b1};
                        r_state <= S_EMIT;
                    end else if (r_phase == PH_SEEK) begin
                        r_res   <= '{drive_enable: 1'b1, target_angle: '0, stop_found: 1'b0,
                                     phase_now: PH_SEEK, bad_valve: 1'b0};
                        r_sum   <= {r_offset[r_v][ANG_W-1], r_offset[r_v]}
                                 + {r_enc[ANG_W-1], r_enc};
                        r_state <= S_MIS;
                    end else begin
                        r_res <= '{
                            drive_enable: !((r_phase == PH_SETTLE) || (r_phase == PH_OFF)),
                            target_angle: (r_phase == PH_HOME) ? r_home_pos : '0,
                            stop_found:   1'b0,
                            phase_now:    w_adv ? w_next_ph : r_phase,
                            bad_valve:    1'b0
                        };
                        if (w_adv) begin
                            r_phase <= w_next_ph;
                        end
                        // first settle tick captures the time stamp
                        if ((r_phase == PH_SETTLE) && !r_stamp_vld) begin
                            r_stamp     <= r_now;
                            r_stamp_vld <= 1'b1;
                        end
                        if (r_phase == PH_HOME) begin
                            r_offset[r_v] <= '0;
                            r_target[r_v] <= r_home_pos;
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_MIS: begin
                    r_mis   <= {{2{r_pos[ANG_W-1]}}, r_pos} - {r_sum[ANG_W], r_sum};
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_in_range) begin
                        // still tracking: wait for the shrinking step
                        r_state <= S_DIV;
                    end else begin
                        r_res   <= '{drive_enable: 1'b1, target_angle: r_enc,
                                     stop_found: 1'b1, phase_now: PH_SETTLE,
                                     bad_valve: 1'b0};
                        r_phase <= PH_SETTLE;
                        if (r_pass < PASS_LIM) begin
                            r_pass <= r_pass + 1'b1;
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_target[r_v]      <= f_sat(w_tadd);
                        r_res.target_angle <= f_sat(w_tadd);
                        r_state            <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // hold until the output register is free
                    if (!r_ov || o_out.ready) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `VHCS_ASSERT_IMP(a_div_done_in_wait, i_clk, i_rst_n, w_div_done, r_state == S_DIV, "quotient arrived outside the divide wait")
    `VHCS_ASSERT_IMP(a_pass_bound, i_clk, i_rst_n, 1'b1, r_pass <= PASS_LIM, "pass count beyond its limit")
    `VHCS_ASSERT_NXT(a_emit_loads, i_clk, i_rst_n, (r_state == S_EMIT) && (!r_ov || o_out.ready), r_ov && (r_state == S_IDLE), "result not loaded on a free output")

endmodule

### tb/sv/hardstop_calib_checker.sv
`timescale 1ns / 100ps
// Watches the sequencer's channels, predicts each tick's result and compares.
module hardstop_calib_checker
    import vhcs_pkg::*;
#(
    parameter int PASS_MAX      = 255,
    parameter int POS_FRAC_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_vhcs_in              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_vhcs_out             i_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_fail_count
);

    localparam longint HOME_FULL = longint'(95) << POS_FRAC_BITS;

    // register copies
    logic [SEEK_W-1:0]       seek_step;
    logic [LIMIT_W-1:0]      track_limit;
    logic [MS_W-1:0]         settle_ms;
    logic [MS_W-1:0]         off_ms;
    logic [MS_W-1:0]         repower_ms;
    logic [MS_W-1:0]         home_ms;
    logic signed [ANG_W-1:0] home_angle;

    // sequencer state
    logic [PHASE_W-1:0]      phase;
    int unsigned             passes;
    logic [TIME_W-1:0]       stamp;
    logic                    stamp_held;
    logic signed [ANG_W-1:0] valve_tgt [2];
    logic signed [ANG_W-1:0] valve_ofs [2];

    t_vhcs_out due_results [$];

    function automatic logic signed [ANG_W-1:0] clamp_angle(input longint val);
        if (val > longint'(ANG_MAX)) begin
            return ANG_MAX;
        end
        if (val < longint'(ANG_MIN)) begin
            return ANG_MIN;
        end
        return ANG_W'(val);
    endfunction

    task automatic advance_sequence(input t_vhcs_in it);
        t_vhcs_out               res;
        logic                    v;
        logic signed [ANG_W-1:0] pos;
        logic signed [ANG_W-1:0] enc;
        logic [TIME_W-1:0]       elapsed;
        longint                  miss;
        int unsigned             inc;
        res     = '0;
        v       = it.valve_sel[0];
        pos     = it.measured_pos;
        enc     = it.encoder_pos;
        elapsed = it.time_ms - stamp;
        if (it.op == OP_RESET) begin
            // unsupported valves are dropped without a result
            if (!it.valve_sel[1]) begin
                phase        = PH_SEEK;
                passes       = 0;
                stamp        = '0;
                stamp_held   = 1'b0;
                valve_tgt[v] = enc;
                valve_ofs[v] = clamp_angle(longint'(pos) - longint'(enc));
            end
        end else if (it.valve_sel[1]) begin
            res.bad_valve = 1'b1;
            due_results.push_back(res);
        end else begin
            res.drive_enable = 1'b1;
            case (phase)
                PH_SEEK: begin
                    miss = longint'(pos) - (longint'(valve_ofs[v]) + longint'(enc));
                    if (miss < 0) begin
                        miss = -miss;
                    end
                    if (miss <= longint'(track_limit)) begin
                        inc = seek_step / (passes + 1);
                        valve_tgt[v] = clamp_angle(longint'(valve_tgt[v]) + longint'(inc));
                        res.target_angle = valve_tgt[v];
                    end else begin
                        res.stop_found   = 1'b1;
                        res.target_angle = enc;
                        if (passes < PASS_MAX) begin
                            passes++;
                        end
                        phase = PH_SETTLE;
                    end
                end
                PH_SETTLE: begin
                    res.drive_enable = 1'b0;
                    if (!stamp_held) begin
                        stamp      = it.time_ms;
                        stamp_held = 1'b1;
                    end else if (elapsed >= settle_ms) begin
                        phase = PH_OFF;
                    end
                end
                PH_OFF: begin
                    res.drive_enable = 1'b0;
                    if (elapsed >= off_ms) begin
                        phase = PH_REPOWER;
                    end
                end
                PH_REPOWER: begin
                    if (elapsed >= repower_ms) begin
                        phase = PH_HOME;
                    end
                end
                PH_HOME: begin
                    res.target_angle = home_angle;
                    valve_ofs[v]     = '0;
                    valve_tgt[v]     = home_angle;
                    if (elapsed >= home_ms) begin
                        phase = PH_SEEK;
                    end
                end
                default: begin
                end
            endcase
            res.phase_now = phase;
            due_results.push_back(res);
        end
    endtask

    task automatic check_result(input t_vhcs_out got);
        t_vhcs_out want;
        if (due_results.size() == 0) begin
            $error("result with nothing pending: phase_now %0d, bad_valve %0b",
                   got.phase_now, got.bad_valve);
            o_fail_count++;
        end else begin
            want = due_results.pop_front();
            if (got.drive_enable !== want.drive_enable) begin
                $error("drive_enable: expected %0b, got %0b",
                       want.drive_enable, got.drive_enable);
                o_fail_count++;
            end
            if (got.target_angle !== want.target_angle) begin
                $error("target_angle: expected %0d, got %0d",
                       want.target_angle, got.target_angle);
                o_fail_count++;
            end
            if (got.stop_found !== want.stop_found) begin
                $error("stop_found: expected %0b, got %0b", want.stop_found, got.stop_found);
                o_fail_count++;
            end
            if (got.phase_now !== want.phase_now) begin
                $error("phase_now: expected %0d, got %0d", want.phase_now, got.phase_now);
                o_fail_count++;
            end
            if (got.bad_valve !== want.bad_valve) begin
                $error("bad_valve: expected %0b, got %0b", want.bad_valve, got.bad_valve);
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seek_step   = SEEK_W'((64'd2 << POS_FRAC_BITS) / 1000);
            track_limit = LIMIT_W'((64'd2 << POS_FRAC_BITS) / 10);
            settle_ms   = SETTLE_MS_RST;
            off_ms      = POWER_OFF_MS_RST;
            repower_ms  = REPOWER_MS_RST;
            home_ms     = HOME_MS_RST;
            home_angle  = (HOME_FULL > longint'(ANG_MAX)) ? ANG_MAX : ANG_W'(HOME_FULL);
            phase       = PH_SEEK;
            passes      = 0;
            stamp       = '0;
            stamp_held  = 1'b0;
            valve_tgt   = '{default: '0};
            valve_ofs   = '{default: '0};
            due_results.delete();
        end else begin
            // an older item's result is compared before a new item is predicted
            if (i_out_valid && i_out_ready) begin
                check_result(i_out_data);
            end
            if (i_in_valid && i_in_ready) begin
                advance_sequence(i_in_data);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SEEK_STEP:      seek_step   = i_cfg_data[SEEK_W-1:0];
                    CFG_TRACKING_LIMIT: track_limit = i_cfg_data[LIMIT_W-1:0];
                    CFG_SETTLE_MS:      settle_ms   = i_cfg_data[MS_W-1:0];
                    CFG_POWER_OFF_MS:   off_ms      = i_cfg_data[MS_W-1:0];
                    CFG_REPOWER_MS:     repower_ms  = i_cfg_data[MS_W-1:0];
                    CFG_HOME_MS:        home_ms     = i_cfg_data[MS_W-1:0];
                    CFG_HOME_POSITION:  home_angle  = i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        o_pending = due_results.size();
    end

endmodule

### tb/sv/valve_hardstop_calibration_sequencer_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, stimulus and verdict for the hard-stop sequencer.
module valve_hardstop_calibration_sequencer_unit_tb;
    import vhcs_pkg::*;

    localparam int PASS_MAX        = 255;
    localparam int POS_FRAC_BITS   = 20;
    // longest tick is a tracking seek step through the divider; leave headroom
    localparam int DRAIN_CYCLES    = 40;
    // roughly 520 items, each at its slowest, taken several times over
    localparam int CYCLE_LIMIT     = 200_000;
    localparam int RANDOM_ITEMS    = 70;
    // enough stop cycles for a few dozen quick passes, so the step shrinks well down
    localparam int CLIMB_TICKS     = 200;
    localparam int TRACK_LIMIT_RST = (2 << POS_FRAC_BITS) / 10;

    localparam logic [SEEK_W-1:0]  SEEK_STEP_MAX   = 21'd1048576;
    localparam logic [LIMIT_W-1:0] TRACK_LIMIT_MAX = 24'd10485760;
    localparam logic [MS_W-1:0]    MS_MAX          = 16'hFFFF;

    // valve codes
    localparam logic [1:0] VALVE_FUEL    = 2'd0;
    localparam logic [1:0] VALVE_OX      = 2'd1;
    localparam logic [1:0] VALVE_SPARE_A = 2'd2;
    localparam logic [1:0] VALVE_SPARE_B = 2'd3;

    // stamp just below the 32-bit wrap, so the timed phases straddle it
    localparam logic [TIME_W-1:0] T0 = 32'hFFFF_FF00;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  in_vld   = 1'b0;
    t_vhcs_in              in_item  = '0;
    logic                  out_rdy  = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  no_idle  = 1'b0;
    int                    pending;
    int                    fail_count;
    int unsigned           cycles   = 0;
    logic [TIME_W-1:0]     now_ms   = 32'hFFFF_0000;
    int                    cur_limit;
    int unsigned           time_span;

    vhcs_chan_if #(.T(t_vhcs_in))  in_ch  ();
    vhcs_chan_if #(.T(t_vhcs_out)) out_ch ();

    assign in_ch.valid  = in_vld;
    assign in_ch.data   = in_item;
    assign out_ch.ready = out_rdy;

    valve_hardstop_calibration_sequencer_unit #(
        .PASS_MAX      (PASS_MAX),
        .POS_FRAC_BITS (POS_FRAC_BITS)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    hardstop_calib_checker #(
        .PASS_MAX      (PASS_MAX),
        .POS_FRAC_BITS (POS_FRAC_BITS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_data    (in_ch.data),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_data   (out_ch.data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #5 clk = ~clk;

    // Guard against a hung handshake: give up well past the slowest correct run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: hold ready low for a drawn number of cycles before each item,
    // then keep it high until the item is taken. Runs of no_idle give back-to-back
    // acceptance so the output register is exercised under full throughput too.
    initial begin : result_sink
        int gap;
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 16);
            if (gap != 0) begin
                out_rdy <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_rdy <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            @(negedge clk);
        end
    end

    function automatic t_vhcs_in make_item(input logic op, input logic [1:0] sel,
                                           input logic [TIME_W-1:0] t,
                                           input logic signed [ANG_W-1:0] pos,
                                           input logic signed [ANG_W-1:0] enc);
        t_vhcs_in it;
        it.op           = op;
        it.valve_sel    = sel;
        it.time_ms      = t;
        it.measured_pos = pos;
        it.encoder_pos  = enc;
        return it;
    endfunction

    // Present one item from a falling edge and hold it until accepted. With no
    // gap the next item replaces it in the same step, so valid never dips.
    task automatic drive_item(input t_vhcs_in it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            in_vld <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item <= it;
        in_vld  <= 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    // Drop valid, wait for every predicted result, then give reset items and
    // any tail of work time to finish before the block is touched again.
    task automatic drain_results();
        in_vld <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
    endtask

    // Write all seven registers in one burst while the block is idle.
    task automatic load_settings(input logic [SEEK_W-1:0] step, input logic [LIMIT_W-1:0] lim,
                                 input logic [MS_W-1:0] settle, input logic [MS_W-1:0] off,
                                 input logic [MS_W-1:0] repower, input logic [MS_W-1:0] home,
                                 input logic signed [ANG_W-1:0] home_pos,
                                 input int unsigned span);
        drain_results();
        cfg_we <= 1'b1;
        put_reg(CFG_SEEK_STEP, CFG_DATA_W'(step));
        put_reg(CFG_TRACKING_LIMIT, CFG_DATA_W'(lim));
        put_reg(CFG_SETTLE_MS, CFG_DATA_W'(settle));
        put_reg(CFG_POWER_OFF_MS, CFG_DATA_W'(off));
        put_reg(CFG_REPOWER_MS, CFG_DATA_W'(repower));
        put_reg(CFG_HOME_MS, CFG_DATA_W'(home));
        put_reg(CFG_HOME_POSITION, home_pos);
        cfg_we    <= 1'b0;
        cur_limit  = int'(lim);
        time_span  = span;
    endtask

    // Mostly well-formed calibration traffic: reset offsets stay within half the
    // tracking limit and tracking noise within a quarter, so a tick tracks whether
    // or not the home phase has cleared the offset; a stop tick overshoots by more
    // than twice the limit. The rest is unsupported valves and raw noise.
    task automatic run_random(input int n_items);
        int                      sent;
        int                      miss;
        int unsigned             r;
        logic [1:0]              sel;
        logic signed [ANG_W-1:0] enc;
        logic signed [ANG_W-1:0] pos;
        t_vhcs_in                it;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 31) == 0) begin
                no_idle = ~no_idle;
            end
            if ($urandom_range(0, 49) == 0) begin
                now_ms = $urandom;
            end else begin
                now_ms += $urandom_range(0, time_span);
            end
            sel = ($urandom_range(0, 1) == 0) ? VALVE_FUEL : VALVE_OX;
            enc = ANG_W'(int'($urandom) >>> 2);
            r   = $urandom_range(0, 99);
            if (r < 70) begin
                pos = enc + ANG_W'(int'($urandom_range(0, cur_limit / 2)) - cur_limit / 4);
                drive_item(make_item(OP_TICK, sel, now_ms, pos, enc));
                sent++;
            end else if (r < 80) begin
                miss = 2 * cur_limit + 1 + int'($urandom_range(0, 1000));
                if ($urandom_range(0, 1) == 0) begin
                    pos = enc + ANG_W'(miss);
                end else begin
                    pos = enc - ANG_W'(miss);
                end
                drive_item(make_item(OP_TICK, sel, now_ms, pos, enc));
                sent++;
            end else if (r < 86) begin
                pos = enc + ANG_W'(int'($urandom_range(0, cur_limit)) - cur_limit / 2);
                drive_item(make_item(OP_RESET, sel, now_ms, pos, enc));
                sent++;
            end else if (r < 89) begin
                // ignored by the block; does not count
                sel = ($urandom_range(0, 1) == 0) ? VALVE_SPARE_A : VALVE_SPARE_B;
                drive_item(make_item(OP_RESET, sel, $urandom, $urandom, $urandom));
            end else if (r < 93) begin
                sel = ($urandom_range(0, 1) == 0) ? VALVE_SPARE_A : VALVE_SPARE_B;
                drive_item(make_item(OP_TICK, sel, $urandom, $urandom, $urandom));
                sent++;
            end else begin
                it = make_item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                               $urandom, $urandom, $urandom);
                drive_item(it);
                if (!(it.op == OP_RESET && it.valve_sel[1])) begin
                    sent++;
                end
            end
        end
    endtask

    initial begin : stimulus
        logic signed [ANG_W-1:0] enc;
        logic signed [ANG_W-1:0] pos;

        // hold reset, then release it clear of the rising edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed part, run on the register defaults ---
        // tick before any calibration reset: target grows from zero
        drive_item(make_item(OP_TICK, VALVE_FUEL, 32'd0, '0, '0));
        // unsupported valves: error flag on a tick, a reset is dropped
        drive_item(make_item(OP_TICK, VALVE_SPARE_A, '1, '1, '1));
        drive_item(make_item(OP_TICK, VALVE_SPARE_B, '0, '0, '0));
        drive_item(make_item(OP_RESET, VALVE_SPARE_A, '1, ANG_MAX, ANG_MIN));
        drive_item(make_item(OP_RESET, VALVE_SPARE_B, '0, '1, '0));
        // target pinned at the top of the angle range
        drive_item(make_item(OP_RESET, VALVE_FUEL, 32'd5, ANG_MAX, ANG_MAX));
        drive_item(make_item(OP_TICK, VALVE_FUEL, 32'd6, ANG_MAX, ANG_MAX));
        // offset saturates high; the wide mismatch then declares the stop
        drive_item(make_item(OP_RESET, VALVE_OX, 32'd7, ANG_MAX, ANG_MIN));
        drive_item(make_item(OP_TICK, VALVE_OX, 32'd8, ANG_MAX, ANG_MIN));
        // walk the timed phases: settle and power-off each just missed then just met, the rest just met
        drive_item(make_item(OP_TICK, VALVE_OX, T0, '0, '0));
        drive_item(make_item(OP_TICK, VALVE_OX, T0 + 32'd999, '0, '0));
        drive_item(make_item(OP_TICK, VALVE_OX, T0 + 32'd1000, '0, '0));
        drive_item(make_item(OP_TICK, VALVE_OX, T0 + 32'd3999, '0, '0));
        drive_item(make_item(OP_TICK, VALVE_OX, T0 + 32'd4000, '0, '0));
        drive_item(make_item(OP_TICK, VALVE_OX, T0 + 32'd5000, '0, '0));
        // unsupported valve in mid-sequence must leave the phase alone
        drive_item(make_item(OP_TICK, VALVE_SPARE_B, T0 + 32'd5001, '0, '0));
        drive_item(make_item(OP_TICK, VALVE_OX, T0 + 32'd6500, '0, '0));
        // back in seek with the offset cleared: mismatch exactly at the limit
        // tracks on both sides, one more declares the stop on the second pass
        enc = 32'sd1000;
        drive_item(make_item(OP_TICK, VALVE_OX, T0 + 32'd6501, enc + TRACK_LIMIT_RST, enc));
        drive_item(make_item(OP_TICK, VALVE_OX, T0 + 32'd6502, enc - TRACK_LIMIT_RST, enc));
        drive_item(make_item(OP_TICK, VALVE_OX, T0 + 32'd6503,
                             enc + TRACK_LIMIT_RST + 1, enc));
        // stamp is kept across passes, so settle ends at once
        drive_item(make_item(OP_TICK, VALVE_OX, T0 + 32'd6600, '0, '0));
        // offset saturates low, then the wide mismatch declares the stop
        drive_item(make_item(OP_RESET, VALVE_FUEL, 32'd9, ANG_MIN, ANG_MAX));
        drive_item(make_item(OP_TICK, VALVE_FUEL, 32'd10, ANG_MIN, ANG_MAX));

        // --- random traffic over several register settings ---
        load_settings(SEEK_W'($urandom_range(0, SEEK_STEP_MAX)),
                      LIMIT_W'($urandom_range(0, TRACK_LIMIT_MAX)),
                      MS_W'($urandom_range(0, 3000)), MS_W'($urandom_range(0, 3000)),
                      MS_W'($urandom_range(0, 3000)), MS_W'($urandom_range(0, 3000)),
                      $urandom, 1500);
        run_random(RANDOM_ITEMS);

        // upper extremes: a large step and limit, longest delays, home at the top
        load_settings(SEEK_STEP_MAX, TRACK_LIMIT_MAX, MS_MAX, MS_MAX, MS_MAX, MS_MAX,
                      ANG_MAX, 30000);
        run_random(RANDOM_ITEMS);

        // lower extremes: no step, exact tracking, no delays, home at the bottom
        load_settings('0, '0, '0, '0, '0, '0, ANG_MIN, 50);
        run_random(RANDOM_ITEMS);

        // climb the pass count over many quick passes: with no delays and exact
        // tracking nearly every seek tick finds the stop; later passes take five ticks
        load_settings(SEEK_STEP_MAX, '0, '0, '0, '0, '0, $urandom, 10);
        enc = ANG_W'(int'($urandom) >>> 2);
        drive_item(make_item(OP_RESET, VALVE_FUEL, now_ms, enc, enc));
        drive_item(make_item(OP_RESET, VALVE_OX, now_ms, enc, enc));
        repeat (CLIMB_TICKS) begin
            if ($urandom_range(0, 31) == 0) begin
                no_idle = ~no_idle;
            end
            now_ms += $urandom_range(0, 10);
            enc = ANG_W'(int'($urandom) >>> 2);
            pos = ($urandom_range(0, 7) == 0) ? enc : enc + 32'sd1;
            drive_item(make_item(OP_TICK, ($urandom_range(0, 1) == 0) ? VALVE_FUEL : VALVE_OX,
                                 now_ms, pos, enc));
        end

        // back to moderate settings for a final random stretch
        load_settings(SEEK_W'($urandom_range(0, 4096)),
                      LIMIT_W'($urandom_range(1000, 500000)),
                      MS_W'($urandom_range(0, 2000)), MS_W'($urandom_range(0, 5000)),
                      MS_W'($urandom_range(0, 6000)), MS_W'($urandom_range(0, 8000)),
                      $urandom, 2500);
        run_random(RANDOM_ITEMS);

        drain_results();
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
